// File: design/tch_pkg.sv
// Shared types, constants and the arctangent table for the tilt-compensated heading unit.
package tch_pkg;

  localparam int ZW = 34;
  localparam int XW = 33;
  localparam int MW = 17;
  localparam int PW = 50;
  localparam int VW = 54;
  localparam int HW = 20;
  localparam int TAB_LEN = 24;

  localparam logic signed [XW-1:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [ZW-1:0] HALF_TURN_Z = 34'sd1179648000;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;
  localparam logic [1:0] REG_DECL     = 2'd3;

  typedef struct packed {
    logic signed [MW-1:0] mx;
    logic signed [MW-1:0] my;
    logic signed [MW-1:0] mz;
    logic                 neg_r;
    logic                 neg_p;
  } rot_side_t;

  function automatic logic signed [ZW-1:0] atan_ent(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 34'sd294912000;
      1:  v = 34'sd174096719;
      2:  v = 34'sd91987925;
      3:  v = 34'sd46694507;
      4:  v = 34'sd23437865;
      5:  v = 34'sd11730358;
      6:  v = 34'sd5866610;
      7:  v = 34'sd2933484;
      8:  v = 34'sd1466764;
      9:  v = 34'sd733385;
      10: v = 34'sd366693;
      11: v = 34'sd183346;
      12: v = 34'sd91673;
      13: v = 34'sd45837;
      14: v = 34'sd22918;
      15: v = 34'sd11459;
      16: v = 34'sd5730;
      17: v = 34'sd2865;
      18: v = 34'sd1432;
      19: v = 34'sd716;
      20: v = 34'sd358;
      21: v = 34'sd179;
      22: v = 34'sd90;
      23: v = 34'sd45;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/tch_rot.sv
// Pipelined rotation-mode CORDIC: sine and cosine of two angles in lockstep.
module tch_rot #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [tch_pkg::ZW-1:0] in_za,
  input  logic signed [tch_pkg::ZW-1:0] in_zb,
  input  tch_pkg::rot_side_t            in_side,
  output logic                          out_vld,
  output logic signed [tch_pkg::XW-1:0] out_ca,
  output logic signed [tch_pkg::XW-1:0] out_sa,
  output logic signed [tch_pkg::XW-1:0] out_cb,
  output logic signed [tch_pkg::XW-1:0] out_sb,
  output tch_pkg::rot_side_t            out_side
);

  logic signed [tch_pkg::XW-1:0] xa [0:STEPS];
  logic signed [tch_pkg::XW-1:0] ya [0:STEPS];
  logic signed [tch_pkg::ZW-1:0] za [0:STEPS];
  logic signed [tch_pkg::XW-1:0] xb [0:STEPS];
  logic signed [tch_pkg::XW-1:0] yb [0:STEPS];
  logic signed [tch_pkg::ZW-1:0] zb [0:STEPS];
  tch_pkg::rot_side_t            sd [0:STEPS];
  logic                          vl [0:STEPS];

  assign xa[0] = tch_pkg::GAIN_Q30;
  assign ya[0] = '0;
  assign za[0] = in_za;
  assign xb[0] = tch_pkg::GAIN_Q30;
  assign yb[0] = '0;
  assign zb[0] = in_zb;
  assign sd[0] = in_side;
  assign vl[0] = in_vld;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (!za[i][tch_pkg::ZW-1]) begin
          xa[i+1] <= xa[i] - (ya[i] >>> i);
          ya[i+1] <= ya[i] + (xa[i] >>> i);
          za[i+1] <= za[i] - tch_pkg::atan_ent(i);
        end else begin
          xa[i+1] <= xa[i] + (ya[i] >>> i);
          ya[i+1] <= ya[i] - (xa[i] >>> i);
          za[i+1] <= za[i] + tch_pkg::atan_ent(i);
        end
        if (!zb[i][tch_pkg::ZW-1]) begin
          xb[i+1] <= xb[i] - (yb[i] >>> i);
          yb[i+1] <= yb[i] + (xb[i] >>> i);
          zb[i+1] <= zb[i] - tch_pkg::atan_ent(i);
        end else begin
          xb[i+1] <= xb[i] + (yb[i] >>> i);
          yb[i+1] <= yb[i] - (xb[i] >>> i);
          zb[i+1] <= zb[i] + tch_pkg::atan_ent(i);
        end
      end
    end
  end

  assign out_vld  = vl[STEPS];
  assign out_ca   = xa[STEPS];
  assign out_sa   = ya[STEPS];
  assign out_cb   = xb[STEPS];
  assign out_sb   = yb[STEPS];
  assign out_side = sd[STEPS];

endmodule

// File: design/tch_vec.sv
// Pipelined vectoring-mode CORDIC: atan2 of the horizontal field.
module tch_vec #(
  parameter int STEPS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic                          in_zero,
  input  logic signed [tch_pkg::VW-1:0] in_x,
  input  logic signed [tch_pkg::VW-1:0] in_y,
  input  logic signed [tch_pkg::ZW-1:0] in_z,
  output logic                          out_vld,
  output logic                          out_zero,
  output logic signed [tch_pkg::ZW-1:0] out_z
);

  logic signed [tch_pkg::VW-1:0] xv [0:STEPS];
  logic signed [tch_pkg::VW-1:0] yv [0:STEPS];
  logic signed [tch_pkg::ZW-1:0] zv [0:STEPS];
  logic                          zf [0:STEPS];
  logic                          vl [0:STEPS];

  assign xv[0] = in_x;
  assign yv[0] = in_y;
  assign zv[0] = in_z;
  assign zf[0] = in_zero;
  assign vl[0] = in_vld;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!yv[i][tch_pkg::VW-1] && (yv[i] != '0)) begin
          xv[i+1] <= xv[i] + (yv[i] >>> i);
          yv[i+1] <= yv[i] - (xv[i] >>> i);
          zv[i+1] <= zv[i] + tch_pkg::atan_ent(i);
        end else begin
          xv[i+1] <= xv[i] - (yv[i] >>> i);
          yv[i+1] <= yv[i] + (xv[i] >>> i);
          zv[i+1] <= zv[i] - tch_pkg::atan_ent(i);
        end
      end
    end
  end

  assign out_vld  = vl[STEPS];
  assign out_zero = zf[STEPS];
  assign out_z    = zv[STEPS];

endmodule

// File: design/tilt_compensated_heading_unit.sv
// Top level of the tilt-compensated compass heading pipeline.
//
//  channel | direction | beat contents
//  in_     | slave     | tdata: roll_angle, pitch_angle, field_x, field_y, field_z
//  out_    | master    | tdata: heading
//  cfg_    | write     | offset_x, offset_y, offset_z, declination by index
//
// One beat enters per cycle while no stall holds the pipeline, which has two CORDIC
// pipelines of one stage per iteration, input, fold, two multiply, sum and
// two output stages. Reset is synchronous, clears valid bits and loads the
// register defaults. A stall at out_tready freezes every stage at once and
// drops in_tready; nothing is lost or repeated.
module tilt_compensated_heading_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // roll_angle[15:0], pitch_angle[30:16], field_x[46:31], field_y[62:47],
  // field_z[78:63], zero pad[79]
  input  logic [79:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // heading[15:0]
  output logic [15:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int NSTEP = (CORDIC_STEPS > tch_pkg::TAB_LEN) ? tch_pkg::TAB_LEN : CORDIC_STEPS;

  logic signed [15:0] off_x_r, off_y_r, off_z_r, decl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      decl_r  <= 16'sd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tch_pkg::REG_OFFSET_X: off_x_r <= cfg_wdata;
        tch_pkg::REG_OFFSET_Y: off_y_r <= cfg_wdata;
        tch_pkg::REG_OFFSET_Z: off_z_r <= cfg_wdata;
        tch_pkg::REG_DECL:     decl_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_valid_r;
  logic [15:0] heading_r;

  assign en         = ~out_valid_r | out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = heading_r;

  // wrap to one turn, fold beyond a quarter turn; returns {neg, angle}
  function automatic logic [17:0] fold(input logic signed [16:0] a_in);
    logic signed [16:0] a;
    logic               neg;
    a   = a_in;
    neg = 1'b0;
    if (a >= 17'sd18000) a = a - 17'sd36000;
    else if (a < -17'sd18000) a = a + 17'sd36000;
    if (a > 17'sd9000) begin
      a   = a - 17'sd18000;
      neg = 1'b1;
    end else if (a < -17'sd9000) begin
      a   = a + 17'sd18000;
      neg = 1'b1;
    end
    return {neg, a};
  endfunction

  // stage 0: fold angles, remove hard-iron offsets
  logic [17:0] fr, fp;
  logic        v0_r;
  logic signed [tch_pkg::ZW-1:0] zr0_r, zp0_r;
  tch_pkg::rot_side_t side0_r;

  assign fr = fold(17'(signed'(in_tdata[15:0])));
  assign fp = fold(17'(signed'(in_tdata[30:16])));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zr0_r         <= tch_pkg::ZW'(signed'({fr[16:0], 16'h0000}));
      zp0_r         <= tch_pkg::ZW'(signed'({fp[16:0], 16'h0000}));
      side0_r.neg_r <= fr[17];
      side0_r.neg_p <= fp[17];
      side0_r.mx    <= 17'(signed'(in_tdata[46:31])) - 17'(off_x_r);
      side0_r.my    <= 17'(signed'(in_tdata[62:47])) - 17'(off_y_r);
      side0_r.mz    <= 17'(signed'(in_tdata[78:63])) - 17'(off_z_r);
    end
  end

  logic rv;
  logic signed [tch_pkg::XW-1:0] cr_w, sr_w, cp_w, sp_w;
  tch_pkg::rot_side_t rside;

  tch_rot #(.STEPS(NSTEP)) u_rot (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v0_r),
    .in_za   (zr0_r),
    .in_zb   (zp0_r),
    .in_side (side0_r),
    .out_vld (rv),
    .out_ca  (cr_w),
    .out_sa  (sr_w),
    .out_cb  (cp_w),
    .out_sb  (sp_w),
    .out_side(rside)
  );

  // stage 1: undo fold
  logic v1_r;
  logic signed [tch_pkg::XW-1:0] sr1_r, cr1_r, sp1_r, cp1_r;
  logic signed [tch_pkg::MW-1:0] mx1_r, my1_r, mz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr1_r <= rside.neg_r ? -sr_w : sr_w;
      cr1_r <= rside.neg_r ? -cr_w : cr_w;
      sp1_r <= rside.neg_p ? -sp_w : sp_w;
      cp1_r <= rside.neg_p ? -cp_w : cp_w;
      mx1_r <= rside.mx;
      my1_r <= rside.my;
      mz1_r <= rside.mz;
    end
  end

  // stage 2: first products
  logic v2_r;
  logic signed [65:0] srsp_p, crsp_p;
  logic signed [tch_pkg::XW-1:0] srsp2_r, crsp2_r;
  logic signed [tch_pkg::PW-1:0] mxcp2_r, mycr2_r, mzsr2_r;
  logic signed [tch_pkg::MW-1:0] my2_r, mz2_r;

  assign srsp_p = 66'(sr1_r) * 66'(sp1_r);
  assign crsp_p = 66'(cr1_r) * 66'(sp1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      srsp2_r <= srsp_p[62:30];
      crsp2_r <= crsp_p[62:30];
      mxcp2_r <= tch_pkg::PW'(mx1_r) * tch_pkg::PW'(cp1_r);
      mycr2_r <= tch_pkg::PW'(my1_r) * tch_pkg::PW'(cr1_r);
      mzsr2_r <= tch_pkg::PW'(mz1_r) * tch_pkg::PW'(sr1_r);
      my2_r   <= my1_r;
      mz2_r   <= mz1_r;
    end
  end

  // stage 3: second products, Yh
  logic v3_r;
  logic signed [tch_pkg::PW-1:0] mysp3_r, mzcp3_r, mxcp3_r;
  logic signed [tch_pkg::PW:0]   yh3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mysp3_r <= tch_pkg::PW'(my2_r) * tch_pkg::PW'(srsp2_r);
      mzcp3_r <= tch_pkg::PW'(mz2_r) * tch_pkg::PW'(crsp2_r);
      mxcp3_r <= mxcp2_r;
      yh3_r   <= (tch_pkg::PW+1)'(mycr2_r) - (tch_pkg::PW+1)'(mzsr2_r);
    end
  end

  // stage 4: Xh
  logic v4_r;
  logic signed [tch_pkg::PW+1:0] xh4_r;
  logic signed [tch_pkg::PW:0]   yh4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xh4_r <= (tch_pkg::PW+2)'(mxcp3_r) + (tch_pkg::PW+2)'(mysp3_r)
             + (tch_pkg::PW+2)'(mzcp3_r);
      yh4_r <= yh3_r;
    end
  end

  // vector on (Xh, -Yh), half-plane flip when Xh is negative
  logic xneg, hzero;
  logic signed [tch_pkg::VW-1:0] vx0, vy0;
  logic signed [tch_pkg::ZW-1:0] vz0;

  assign xneg  = xh4_r[tch_pkg::PW+1];
  assign hzero = (xh4_r == '0) && (yh4_r == '0);
  assign vx0   = xneg ? -tch_pkg::VW'(xh4_r) : tch_pkg::VW'(xh4_r);
  assign vy0   = xneg ? tch_pkg::VW'(yh4_r) : -tch_pkg::VW'(yh4_r);
  assign vz0   = xneg ? tch_pkg::HALF_TURN_Z : '0;

  logic vv, vzero;
  logic signed [tch_pkg::ZW-1:0] vz;

  tch_vec #(.STEPS(NSTEP)) u_vec (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v4_r),
    .in_zero (hzero),
    .in_x    (vx0),
    .in_y    (vy0),
    .in_z    (vz0),
    .out_vld (vv),
    .out_zero(vzero),
    .out_z   (vz)
  );

  // stage 6: declination, round
  logic v6_r;
  logic signed [35:0] hsum;
  logic signed [tch_pkg::HW-1:0] h6_r;
  logic signed [31:0] decl_sh;

  assign decl_sh = signed'({decl_r, 16'h0000});
  assign hsum    = (vzero ? 36'sd0 : 36'(vz)) + 36'(decl_sh) + 36'sd32768;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= vv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h6_r <= hsum[35:16];
    end
  end

  // output stage: wrap into one turn
  logic signed [tch_pkg::HW-1:0] hw;

  always_comb begin
    if (h6_r < -20'sd36000)     hw = h6_r + 20'sd72000;
    else if (h6_r < 20'sd0)     hw = h6_r + 20'sd36000;
    else if (h6_r >= 20'sd36000) hw = h6_r - 20'sd36000;
    else                        hw = h6_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      heading_r <= hw[15:0];
    end
  end

endmodule
